@@ hdl/assert_macros.svh @@
// assertion macros for the rtl of the ground height block
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define GGH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must be followed by a consequence in the next cycle
`define GGH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/ggh_pkg.sv @@
// shared types, constants and helpers for the ground height difference block
// no dependencies
`timescale 1ns / 1ps

package ggh_pkg;

    localparam int CFG_W      = 10;
    localparam int ROW_OUT_W  = 9;
    localparam int COL_OUT_W  = 9;
    localparam int DIFF_W     = 13;
    localparam int OUT_DATA_W = 32;
    localparam int DIM_MIN    = 3;

    localparam logic [CFG_W-1:0] DIM_RESET = 10'd500;

    // register select, taken from paddr bit 2
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [DIFF_W-1:0] diff;
    } t_ground;

    typedef struct packed {
        logic [DIFF_W-1:0]    diff;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic                 valid;
        logic                 last;
    } t_result;

    // last usable index of a dimension after clamping to [3, maxv]
    function automatic int dim_last(input logic [CFG_W-1:0] v, input int maxv);
        int d;
        d = int'(v);
        if (d < DIM_MIN) begin
            d = DIM_MIN;
        end
        if (d > maxv) begin
            d = maxv;
        end
        return d - 1;
    endfunction

endpackage

@@ hdl/ggh_ground.sv @@
// 3x3 masked minimum and height difference for one interior cell
// depends on ggh_pkg
`timescale 1ns / 1ps

module ggh_ground #(
    parameter int HEIGHT_BITS = 13
) (
    input  logic [8:0][2*HEIGHT_BITS:0] i_nbhd,   // cell: has, min, max from bit 0 up
    output ggh_pkg::t_ground            o_res
);

    localparam int H      = HEIGHT_BITS;
    localparam int DIFF_W = ggh_pkg::DIFF_W;

    logic signed [H-1:0] lo_m [9];
    logic signed [H-1:0] min_l1 [4];
    logic signed [H-1:0] min_l2 [2];
    logic signed [H-1:0] min_l3;
    logic signed [H-1:0] ground;
    logic signed [H-1:0] ctr_hi;
    logic signed [H:0]   diff;

    function automatic logic signed [H-1:0] min2(input logic signed [H-1:0] a,
                                                 input logic signed [H-1:0] b);
        return (b < a) ? b : a;
    endfunction

    // cells without data take the centre minimum so they leave the result unchanged
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            lo_m[i] = i_nbhd[i][0] ? i_nbhd[i][H:1] : i_nbhd[4][H:1];
        end
        for (int i = 0; i < 4; i++) begin
            min_l1[i] = min2(lo_m[2*i], lo_m[2*i+1]);
        end
        min_l2[0] = min2(min_l1[0], min_l1[1]);
        min_l2[1] = min2(min_l1[2], min_l1[3]);
        min_l3    = min2(min_l2[0], min_l2[1]);
        ground    = min2(min_l3, lo_m[8]);
    end

    assign ctr_hi = i_nbhd[4][2*H:H+1];
    assign diff   = {ctr_hi[H-1], ctr_hi} - {ground[H-1], ground};

    always_comb begin
        o_res.valid = i_nbhd[4][0];
        if (!i_nbhd[4][0] || diff[H]) begin
            o_res.diff = '0;
        end else begin
            o_res.diff = DIFF_W'(diff[H-1:0]);
        end
    end

endmodule

@@ hdl/grid_ground_height_difference.sv @@
// top level: line buffers, 3x3 window, result sequencing and register port
// depends on ggh_pkg, ggh_ground and assert_macros.svh
//
// Cells enter in raster order on the s_axis channel (tuser = has-data flag,
// tdata = min and max height). Each accepted cell gives zero, one or two
// results on m_axis: the interior cell one row and one column back, once its
// 3x3 neighbourhood is complete, and then the cell itself if it lies on the
// frame border. tlast marks the final result of an input cell.
// Grid size is set over the APB port (grid_rows at 0x0, grid_cols at 0x4);
// a write restarts the frame and must be done while the block is idle.
// The first result of a cell passes the window stage and then the output register.
// One cell per cycle is taken while m_axis_tready is high and each cell gives at most one
// result; a cell with two results stays in the window stage until both have been emitted.
// The line buffer is one 512-deep memory (both previous rows side by side),
// read once at accept and written once as the cell leaves the window stage.
// Reset sets both dimensions to 500, clears the counters and the window;
// the line buffer is not reset; rows 0 and 1 fill it before any result uses it.
// When m_axis_tready is low the output register holds its result and
// s_axis_tready drops once the window stage is also full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_ground_height_difference #(
    parameter int MAX_COLS    = 512,
    parameter int MAX_ROWS    = 512,
    parameter int HEIGHT_BITS = 13
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // input items
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((2*HEIGHT_BITS+7)/8)*8-1:0]        s_axis_tdata,  // lowest, highest height
    input  logic [0:0]                                s_axis_tuser,  // data flag
    // result items
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [ggh_pkg::OUT_DATA_W-1:0]            m_axis_tdata,  // out_row, out_col, rise, pad
    output logic [0:0]                                m_axis_tuser,  // cell_valid
    output logic                                      m_axis_tlast,  // run_last
    // configuration
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [2:0]                                paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    localparam int H      = HEIGHT_BITS;
    localparam int CW     = 2*HEIGHT_BITS + 1;
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CLW    = $clog2(MAX_COLS);
    localparam int CFG_W  = ggh_pkg::CFG_W;
    localparam int OROW_W = ggh_pkg::ROW_OUT_W;
    localparam int OCOL_W = ggh_pkg::COL_OUT_W;
    localparam int DIFF_W = ggh_pkg::DIFF_W;
    localparam logic [RW-1:0]  ROW_LAST_RST =
        RW'(ggh_pkg::dim_last(ggh_pkg::DIM_RESET, MAX_ROWS));
    localparam logic [CLW-1:0] COL_LAST_RST =
        CLW'(ggh_pkg::dim_last(ggh_pkg::DIM_RESET, MAX_COLS));

    // configuration
    logic [CFG_W-1:0] r_grid_rows;
    logic [CFG_W-1:0] r_grid_cols;
    logic [RW-1:0]    r_row_last;
    logic [CLW-1:0]   r_col_last;
    logic             cfg_we;

    // position of the next cell
    logic [RW-1:0]  r_row, n_row;
    logic [CLW-1:0] r_col, n_col;

    // window stage
    logic            r_s1_v;
    logic            r_s1_sub;
    logic            r_s1_int;
    logic            r_s1_bdr;
    logic [CW-1:0]   r_s1_cur;
    logic [RW-1:0]   r_s1_row;
    logic [CLW-1:0]  r_s1_col;
    logic [2*CW-1:0] r_rd;
    logic [CW-1:0]   r_win [6];
    logic [CW-1:0]   top, mid;
    logic [8:0][CW-1:0] nbhd;
    ggh_pkg::t_ground ground;

    // line buffer: upper half previous row, lower half the row before
    logic [2*CW-1:0] mem [MAX_COLS];

    // output stage
    logic             r_o_v;
    ggh_pkg::t_result r_o;
    ggh_pkg::t_result cand;
    logic             has_res;
    logic             out_free;
    logic             s1_emit;
    logic             s1_retire;
    logic             accept;
    logic             n_int, n_bdr;
    logic [RW-1:0]    int_row;
    logic [CLW-1:0]   int_col;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= ggh_pkg::DIM_RESET;
            r_grid_cols <= ggh_pkg::DIM_RESET;
            r_row_last  <= ROW_LAST_RST;
            r_col_last  <= COL_LAST_RST;
        end else if (cfg_we) begin
            case (paddr[2])
                ggh_pkg::REG_GRID_ROWS: begin
                    r_grid_rows <= pwdata[CFG_W-1:0];
                    r_row_last  <= RW'(ggh_pkg::dim_last(pwdata[CFG_W-1:0], MAX_ROWS));
                end
                ggh_pkg::REG_GRID_COLS: begin
                    r_grid_cols <= pwdata[CFG_W-1:0];
                    r_col_last  <= CLW'(ggh_pkg::dim_last(pwdata[CFG_W-1:0], MAX_COLS));
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ggh_pkg::REG_GRID_ROWS: prdata = {{(32-CFG_W){1'b0}}, r_grid_rows};
            ggh_pkg::REG_GRID_COLS: prdata = {{(32-CFG_W){1'b0}}, r_grid_cols};
            default:                prdata = '0;
        endcase
    end

    // ---------------- input side and position ----------------
    assign s_axis_tready = !r_s1_v || s1_retire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (r_col == r_col_last) begin
            n_col = '0;
            n_row = (r_row == r_row_last) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CLW'(1);
            n_row = r_row;
        end
    end

    assign n_int = (r_row >= RW'(2)) && (r_col >= CLW'(2));
    assign n_bdr = (r_row == '0) || (r_row == r_row_last) ||
                   (r_col == '0) || (r_col == r_col_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ---------------- line buffer ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[r_col];
        end
        if (s1_retire) begin
            mem[r_s1_col] <= {r_s1_cur, mid};
        end
    end

    assign top = r_rd[CW-1:0];
    assign mid = r_rd[2*CW-1:CW];

    // ---------------- window stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s1_sub <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_retire) begin
                r_s1_v <= 1'b0;
            end
            if (s1_retire) begin
                r_s1_sub <= 1'b0;
            end else if (s1_emit) begin
                r_s1_sub <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur <= {s_axis_tdata[2*H-1:H], s_axis_tdata[H-1:0], s_axis_tuser[0]};
            r_s1_row <= r_row;
            r_s1_col <= r_col;
            r_s1_int <= n_int;
            r_s1_bdr <= n_bdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_retire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_s1_cur;
        end
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            nbhd[i] = r_win[i];
        end
        nbhd[6] = top;
        nbhd[7] = mid;
        nbhd[8] = r_s1_cur;
    end

    ggh_ground #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_ground (
        .i_nbhd (nbhd),
        .o_res  (ground)
    );

    // ---------------- result sequencing ----------------
    assign int_row = r_s1_row - RW'(1);
    assign int_col = r_s1_col - CLW'(1);

    // interior cell first, then the border cell
    always_comb begin
        if (r_s1_int && !r_s1_sub) begin
            cand.row   = OROW_W'(int_row);
            cand.col   = OCOL_W'(int_col);
            cand.valid = ground.valid;
            cand.diff  = ground.diff;
            cand.last  = !r_s1_bdr;
        end else begin
            cand.row   = OROW_W'(r_s1_row);
            cand.col   = OCOL_W'(r_s1_col);
            cand.valid = r_s1_cur[0];
            cand.diff  = '0;
            cand.last  = 1'b1;
        end
    end

    assign has_res   = (r_s1_int && !r_s1_sub) || r_s1_bdr;
    assign out_free  = !r_o_v || m_axis_tready;
    assign s1_emit   = r_s1_v && has_res && out_free;
    assign s1_retire = r_s1_v && (!has_res || (out_free && cand.last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_emit) begin
            r_o_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_o <= cand;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {{(ggh_pkg::OUT_DATA_W-DIFF_W-OCOL_W-OROW_W){1'b0}},
                            r_o.diff, r_o.col, r_o.row};
    assign m_axis_tuser  = r_o.valid;
    assign m_axis_tlast  = r_o.last;

    // ---------------- assertions ----------------
    `GGH_ASSERT(a_row_range, i_clk, i_rst_n, r_row_last >= r_row,
        "row counter beyond last row")
    `GGH_ASSERT(a_col_range, i_clk, i_rst_n, r_col_last >= r_col,
        "column counter beyond last column")
    `GGH_ASSERT(a_sub_two, i_clk, i_rst_n, !r_s1_sub || (r_s1_v && r_s1_int && r_s1_bdr),
        "second result pending for an item without two results")
    `GGH_ASSERT_NEXT(a_accept_fill, i_clk, i_rst_n, accept, r_s1_v,
        "accepted item missing from window stage")
    `GGH_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, cfg_we, (r_row == '0) && (r_col == '0),
        "register write did not restart the frame")

endmodule
